>>> design/assert_macros.svh
// Assertion macros used by the console line store back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition on every clock edge outside reset
`define TCLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a trigger is followed by a condition on the next edge
`define TCLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define TCLS_ASSERT(lbl, clk, rstn, prop, msg)
`define TCLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/tcls_pkg.sv
// Shared constants, codes and types of the console line store
package tcls_pkg;

  localparam int LINE_COLUMNS     = 78;
  localparam int SCROLLBACK_LINES = 400;
  localparam int CELLS            = LINE_COLUMNS * SCROLLBACK_LINES;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int LINE_W = 9;
  localparam int COL_W  = 7;
  localparam int SLOT_W = $clog2(SCROLLBACK_LINES);
  localparam int ADDR_W = $clog2(CELLS);

  localparam int TAB_SPACES = 4;
  localparam int REP_W      = $clog2(TAB_SPACES);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // Command classes handed from front to back
  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_TAB     = 3'd1;
  localparam logic [2:0] CMD_NEWLINE = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_ERASE   = 3'd4;
  localparam logic [2:0] CMD_IGNORE  = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  // Result event kinds
  localparam logic [KIND_W-1:0] EV_WRITTEN = 3'd0;
  localparam logic [KIND_W-1:0] EV_STARTED = 3'd1;
  localparam logic [KIND_W-1:0] EV_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] EV_CLEARED = 3'd3;
  localparam logic [KIND_W-1:0] EV_ERASED  = 3'd4;
  localparam logic [KIND_W-1:0] EV_IGNORED = 3'd5;
  localparam logic [KIND_W-1:0] EV_READ    = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] ch;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line_index;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] char_out;
    logic [LINE_W-1:0] line_count;
    logic              last;
  } res_t;

endpackage

>>> design/tcls_ram.sv
// Generic simple dual-port RAM with registered read
module tcls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/tcls_front.sv
// Front end: classifies incoming words and queues them for the back end
module tcls_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [tcls_pkg::CHAR_W-1:0] in_char_in,
  input  logic [tcls_pkg::LINE_W-1:0] in_read_line,
  input  logic [tcls_pkg::COL_W-1:0]  in_read_col,
  output logic                        cmd_valid,
  output tcls_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);
  import tcls_pkg::*;

  cmd_t              cls;
  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  always_comb begin
    cls.ch   = in_char_in;
    cls.line = in_read_line;
    cls.col  = in_read_col;
    if (in_opcode) begin
      cls.op = CMD_READ;
    end else begin
      unique case (in_char_in)
        CH_NL:   cls.op = CMD_NEWLINE;
        CH_FF:   cls.op = CMD_CLEAR;
        CH_BS:   cls.op = CMD_ERASE;
        CH_TAB:  cls.op = CMD_TAB;
        default: cls.op = (in_char_in < CH_SPACE) ? CMD_IGNORE : CMD_PUT;
      endcase
    end
  end

  assign in_stall  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/tcls_back.sv
// Back end: executes console commands against the line ring and emits results
`include "assert_macros.svh"

module tcls_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tcls_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output tcls_pkg::res_t res
);
  import tcls_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_RD_SLOT  = 3'd2;
  localparam logic [2:0] ST_RD_ADDR  = 3'd3;
  localparam logic [2:0] ST_RD_CHECK = 3'd4;
  localparam logic [2:0] ST_RD_EMIT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [REP_W-1:0]  reps_r, reps_nxt;
  logic [LINE_W-1:0] held_r, held_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] newest_r, newest_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [COL_W-1:0]  cursor_r, cursor_nxt;

  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              rd_newest_r, rd_newest_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic              emit, out_free;

  // Start-of-line helpers
  logic [LINE_W-1:0] held_m1, sl_held, sl_line;
  logic [KIND_W-1:0] sl_kind;
  logic              full, wrap_needed, do_start;
  logic [SLOT_W-1:0] newest_adv, oldest_adv;
  logic [ADDR_W-1:0] base_adv;
  logic [CHAR_W-1:0] put_ch;
  logic [LINE_W:0]   rd_sum;
  logic [COL_W-1:0]  rd_lim;

  logic              cell_we, cell_re;
  logic [ADDR_W-1:0] cell_waddr;
  logic [CHAR_W-1:0] cell_rdata;
  logic              len_we, len_re;
  logic [COL_W-1:0]  len_rdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;

  assign held_m1     = held_r - 1'b1;
  assign full        = (held_r == LINE_W'(SCROLLBACK_LINES));
  assign sl_held     = full ? held_r : held_r + 1'b1;
  assign sl_line     = full ? held_m1 : held_r;
  assign sl_kind     = full ? EV_DROPPED : EV_STARTED;
  assign wrap_needed = (cursor_r >= COL_W'(LINE_COLUMNS));
  assign newest_adv  = (newest_r == SLOT_W'(SCROLLBACK_LINES - 1)) ? '0 : newest_r + 1'b1;
  assign oldest_adv  = (oldest_r == SLOT_W'(SCROLLBACK_LINES - 1)) ? '0 : oldest_r + 1'b1;
  assign base_adv    = (newest_r == SLOT_W'(SCROLLBACK_LINES - 1)) ? '0 :
                       base_r + ADDR_W'(LINE_COLUMNS);
  assign put_ch      = (cmd_r.op == CMD_TAB) ? CH_SPACE : cmd_r.ch;
  assign cell_waddr  = base_r + ADDR_W'(cursor_r);
  assign rd_sum      = (LINE_W+1)'(oldest_r) + (LINE_W+1)'(cmd_r.line);
  // The newest line's length is the cursor; the stored length may be stale
  assign rd_lim      = rd_newest_r ? cursor_r : len_rdata;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    reps_nxt      = reps_r;
    held_nxt      = held_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    base_nxt      = base_r;
    cursor_nxt    = cursor_r;
    rd_slot_nxt   = rd_slot_r;
    rd_hit_nxt    = rd_hit_r;
    rd_newest_nxt = rd_newest_r;
    rd_addr_nxt   = rd_addr_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    emit          = 1'b0;
    do_start      = 1'b0;
    cell_we       = 1'b0;
    cell_re       = 1'b0;
    len_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          reps_nxt  = (cmd.op == CMD_TAB) ? REP_W'(TAB_SPACES - 1) : '0;
          state_nxt = (cmd.op == CMD_READ) ? ST_RD_SLOT : ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          case (cmd_r.op)
            CMD_NEWLINE: begin
              do_start  = 1'b1;
              res_nxt   = '{sl_kind, sl_line, '0, '0, sl_held, 1'b1};
              state_nxt = ST_IDLE;
            end
            CMD_CLEAR: begin
              held_nxt   = LINE_W'(1);
              oldest_nxt = '0;
              newest_nxt = '0;
              base_nxt   = '0;
              cursor_nxt = '0;
              res_nxt    = '{EV_CLEARED, '0, '0, '0, LINE_W'(1), 1'b1};
              state_nxt  = ST_IDLE;
            end
            CMD_ERASE: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                res_nxt    = '{EV_ERASED, held_m1, cursor_r - 1'b1, '0, held_r, 1'b1};
              end else begin
                res_nxt    = '{EV_IGNORED, held_m1, '0, '0, held_r, 1'b1};
              end
              state_nxt = ST_IDLE;
            end
            CMD_PUT, CMD_TAB: begin
              if (wrap_needed) begin
                // Wrap first, then write the cell on the next pass
                do_start = 1'b1;
                res_nxt  = '{sl_kind, sl_line, '0, '0, sl_held, 1'b0};
              end else begin
                cell_we    = 1'b1;
                cursor_nxt = cursor_r + 1'b1;
                res_nxt    = '{EV_WRITTEN, held_m1, cursor_r, put_ch, held_r, reps_r == '0};
                if (reps_r == '0) begin
                  state_nxt = ST_IDLE;
                end else begin
                  reps_nxt = reps_r - 1'b1;
                end
              end
            end
            default: begin
              res_nxt   = '{EV_IGNORED, held_m1, cursor_r, '0, held_r, 1'b1};
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_RD_SLOT: begin
        rd_hit_nxt    = (cmd_r.line < held_r);
        rd_newest_nxt = (cmd_r.line == held_m1);
        if (!(cmd_r.line < held_r)) begin
          rd_slot_nxt = '0;
        end else if (rd_sum >= (LINE_W+1)'(SCROLLBACK_LINES)) begin
          rd_slot_nxt = SLOT_W'(rd_sum - (LINE_W+1)'(SCROLLBACK_LINES));
        end else begin
          rd_slot_nxt = SLOT_W'(rd_sum);
        end
        state_nxt = ST_RD_ADDR;
      end

      ST_RD_ADDR: begin
        len_re      = 1'b1;
        rd_addr_nxt = ADDR_W'(rd_slot_r) * ADDR_W'(LINE_COLUMNS) + ADDR_W'(cmd_r.col);
        state_nxt   = ST_RD_CHECK;
      end

      ST_RD_CHECK: begin
        rd_ok_nxt = rd_hit_r && (cmd_r.col < rd_lim) && (cmd_r.col < COL_W'(LINE_COLUMNS));
        cell_re   = rd_ok_nxt;
        state_nxt = ST_RD_EMIT;
      end

      ST_RD_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          res_nxt   = '{EV_READ, cmd_r.line, cmd_r.col, rd_ok_r ? cell_rdata : '0,
                        held_r, 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Close the newest line and open the next slot
    if (do_start) begin
      newest_nxt = newest_adv;
      base_nxt   = base_adv;
      held_nxt   = sl_held;
      cursor_nxt = '0;
      if (full) begin
        oldest_nxt = oldest_adv;
      end
    end
  end

  assign len_we = do_start;

  tcls_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (put_ch),
    .rd_en   (cell_re),
    .rd_addr (rd_addr_r),
    .rd_data (cell_rdata)
  );

  tcls_ram #(
    .WIDTH (COL_W),
    .DEPTH (SCROLLBACK_LINES)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (newest_r),
    .wr_data (cursor_r),
    .rd_en   (len_re),
    .rd_addr (rd_slot_r),
    .rd_data (len_rdata)
  );

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    rd_slot_r   <= rd_slot_nxt;
    rd_hit_r    <= rd_hit_nxt;
    rd_newest_r <= rd_newest_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      reps_r      <= '0;
      held_r      <= LINE_W'(1);
      oldest_r    <= '0;
      newest_r    <= '0;
      base_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      reps_r   <= reps_nxt;
      held_r   <= held_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      base_r   <= base_nxt;
      cursor_r <= cursor_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `TCLS_ASSERT(a_held_range, clk, rst_n, (held_r != '0 && held_r <= LINE_W'(SCROLLBACK_LINES)), "line count out of range")
  `TCLS_ASSERT(a_cursor_range, clk, rst_n, (cursor_r <= COL_W'(LINE_COLUMNS)), "cursor beyond line limit")
  `TCLS_ASSERT(a_base_slot, clk, rst_n, (base_r == ADDR_W'(newest_r) * ADDR_W'(LINE_COLUMNS)), "newest line base does not match its slot")
  `TCLS_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid_r && out_stall), (out_valid_r && $stable(res_r)), "pending result overwritten")

endmodule

>>> design/text_console_line_store_core.sv
// Text console line store top level: one word in, one to five words out.
// A put word passes the back end as a pop, then a write or line start, plus one
// more pass per extra result; a read steps through the slot sum, the
// slot-to-address multiply and the registered reads of the line length and cell
// memories. The front end classifies words and buffers up to two ahead of the
// back end, so input keeps flowing while a result waits at the output register
// until the buffer fills. Cell memory needs no clearing pass after reset.
module text_console_line_store_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [tcls_pkg::CHAR_W-1:0] in_char_in,
  input  logic [tcls_pkg::LINE_W-1:0] in_read_line,
  input  logic [tcls_pkg::COL_W-1:0]  in_read_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcls_pkg::KIND_W-1:0] out_event_kind,
  output logic [tcls_pkg::LINE_W-1:0] out_line_index,
  output logic [tcls_pkg::COL_W-1:0]  out_column,
  output logic [tcls_pkg::CHAR_W-1:0] out_char_out,
  output logic [tcls_pkg::LINE_W-1:0] out_line_count,
  output logic                        out_last
);
  import tcls_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  tcls_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_char_in   (in_char_in),
    .in_read_line (in_read_line),
    .in_read_col  (in_read_col),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tcls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_event_kind = res.kind;
  assign out_line_index = res.line_index;
  assign out_column     = res.column;
  assign out_char_out   = res.char_out;
  assign out_line_count = res.line_count;
  assign out_last       = res.last;

endmodule
